/* hdl/wsd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_pkg
// shared types and constants for the websocket frame deframer
// ----------------------------------------------------------------------------
package wsd_pkg;

    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_SECOND  = 3'd1,
        PH_EXT16   = 3'd2,
        PH_EXT64   = 3'd3,
        PH_KEY     = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_ERROR   = 3'd6
    } phase_t;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_PAYLOAD = 2'd0;
    localparam kind_t KIND_HEADER  = 2'd1;
    localparam kind_t KIND_ERROR   = 2'd2;

    localparam logic [7:0] FIN_BIT    = 8'h80;
    localparam logic [6:0] LEN_MASK   = 7'h7F;
    localparam logic [6:0] LEN_CODE16 = 7'd126;
    localparam logic [6:0] LEN_CODE64 = 7'd127;

    localparam logic [3:0] HDR_BASE   = 4'd2;
    localparam logic [3:0] HDR_END16  = 4'd4;
    localparam logic [3:0] HDR_END64  = 4'd10;

endpackage

/* hdl/websocket_frame_deframer.sv */
`timescale 1ns / 1ps
// a result word appears in the result register in the cycle after its byte is taken
// throughput: one frame byte per cycle, sustained, while the result side keeps up
// frame_stall follows result_stall combinationally while a result word is held
// reset (rst_n low, asynchronous) returns to awaiting the first header byte, no result pending
// after a first byte with fin clear the block drops every byte until the next reset
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// parses frame headers and unmasks payload bytes, one byte per word
// ----------------------------------------------------------------------------
module websocket_frame_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        frame_valid,
    output logic        frame_stall,
    input  logic [7:0]  frame_byte,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  kind,
    output logic [7:0]  payload_byte,
    output logic [3:0]  opcode,
    output logic [63:0] payload_length,
    output logic [3:0]  header_length,
    output logic        last
);

    wsd_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  header_count_reg, header_count_next;
    logic [63:0] length_reg, length_next;
    logic [63:0] remaining_reg, remaining_next;
    logic [31:0] mask_key_reg, mask_key_next;
    logic        masked_reg, masked_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic [1:0]  key_index_reg, key_index_next;

    logic        result_valid_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  payload_byte_reg;
    logic [3:0]  res_opcode_reg;
    logic [63:0] payload_length_reg;
    logic [3:0]  header_length_reg;
    logic        last_reg;

    logic        accept;
    logic        emit;
    logic [1:0]  res_kind;
    logic [7:0]  res_byte;
    logic [63:0] res_length;
    logic [3:0]  res_hlen;
    logic        res_last;
    logic        len_done;
    logic [63:0] len_now;
    logic [63:0] rem_dec;
    logic [7:0]  key_byte;

    assign frame_stall = result_valid_reg && result_stall;
    assign accept      = frame_valid && !frame_stall;

    assign rem_dec  = remaining_reg - 64'd1;
    assign key_byte = masked_reg ? mask_key_reg[(5'd31 - {key_index_reg, 3'b000}) -: 8] : 8'h00;

    // next state
    always_comb
    begin
        phase_next        = phase_reg;
        header_count_next = header_count_reg;
        length_next       = length_reg;
        remaining_next    = remaining_reg;
        mask_key_next     = mask_key_reg;
        masked_next       = masked_reg;
        opcode_next       = opcode_reg;
        key_index_next    = key_index_reg;
        len_done          = 1'b0;
        len_now           = length_reg;

        case (phase_reg)
            wsd_pkg::PH_FIRST:
            begin
                opcode_next       = frame_byte[3:0];
                header_count_next = 4'd1;
                length_next       = 64'd0;
                if ((frame_byte & wsd_pkg::FIN_BIT) == 8'h00)
                begin
                    phase_next = wsd_pkg::PH_ERROR;
                end
                else
                begin
                    phase_next = wsd_pkg::PH_SECOND;
                end
            end
            wsd_pkg::PH_SECOND:
            begin
                masked_next       = frame_byte[7];
                header_count_next = wsd_pkg::HDR_BASE;
                length_next       = 64'd0;
                if ((frame_byte[6:0] & wsd_pkg::LEN_MASK) == wsd_pkg::LEN_CODE16)
                begin
                    phase_next = wsd_pkg::PH_EXT16;
                end
                else if ((frame_byte[6:0] & wsd_pkg::LEN_MASK) == wsd_pkg::LEN_CODE64)
                begin
                    phase_next = wsd_pkg::PH_EXT64;
                end
                else
                begin
                    len_now     = {57'd0, frame_byte[6:0]};
                    length_next = len_now;
                    len_done    = 1'b1;
                end
            end
            wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64:
            begin
                len_now           = {length_reg[55:0], frame_byte};
                length_next       = len_now;
                header_count_next = header_count_reg + 4'd1;
                if ((phase_reg == wsd_pkg::PH_EXT16 && header_count_next == wsd_pkg::HDR_END16) ||
                    (phase_reg == wsd_pkg::PH_EXT64 && header_count_next == wsd_pkg::HDR_END64))
                begin
                    len_done = 1'b1;
                end
            end
            wsd_pkg::PH_KEY:
            begin
                mask_key_next     = {mask_key_reg[23:0], frame_byte};
                header_count_next = header_count_reg + 4'd1;
                key_index_next    = key_index_reg + 2'd1;
                if (key_index_reg == 2'd3)
                begin
                    key_index_next = 2'd0;
                    remaining_next = length_reg;
                    phase_next     = (length_reg == 64'd0) ? wsd_pkg::PH_FIRST
                                                           : wsd_pkg::PH_PAYLOAD;
                end
            end
            wsd_pkg::PH_PAYLOAD:
            begin
                key_index_next = key_index_reg + 2'd1;
                remaining_next = rem_dec;
                if (rem_dec == 64'd0)
                begin
                    phase_next = wsd_pkg::PH_FIRST;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        // length complete: collect the key or close the header
        if (len_done)
        begin
            if (masked_next)
            begin
                key_index_next = 2'd0;
                mask_key_next  = 32'd0;
                phase_next     = wsd_pkg::PH_KEY;
            end
            else
            begin
                remaining_next = len_now;
                key_index_next = 2'd0;
                phase_next     = (len_now == 64'd0) ? wsd_pkg::PH_FIRST
                                                    : wsd_pkg::PH_PAYLOAD;
            end
        end
    end

    // result word
    always_comb
    begin
        emit       = 1'b0;
        res_kind   = wsd_pkg::KIND_PAYLOAD;
        res_byte   = 8'h00;
        res_length = 64'd0;
        res_hlen   = 4'd0;
        res_last   = 1'b0;

        case (phase_reg)
            wsd_pkg::PH_FIRST:
            begin
                if ((frame_byte & wsd_pkg::FIN_BIT) == 8'h00)
                begin
                    emit     = 1'b1;
                    res_kind = wsd_pkg::KIND_ERROR;
                    res_last = 1'b1;
                end
            end
            wsd_pkg::PH_KEY:
            begin
                if (key_index_reg == 2'd3)
                begin
                    emit       = 1'b1;
                    res_kind   = wsd_pkg::KIND_HEADER;
                    res_length = length_reg;
                    res_hlen   = header_count_next;
                    res_last   = (length_reg == 64'd0);
                end
            end
            wsd_pkg::PH_PAYLOAD:
            begin
                emit     = 1'b1;
                res_kind = wsd_pkg::KIND_PAYLOAD;
                res_byte = frame_byte ^ key_byte;
                res_last = (rem_dec == 64'd0);
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase

        if (len_done && !masked_next)
        begin
            emit       = 1'b1;
            res_kind   = wsd_pkg::KIND_HEADER;
            res_length = len_now;
            res_hlen   = header_count_next;
            res_last   = (len_now == 64'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= wsd_pkg::PH_FIRST;
            header_count_reg <= 4'd0;
            length_reg       <= 64'd0;
            remaining_reg    <= 64'd0;
            mask_key_reg     <= 32'd0;
            masked_reg       <= 1'b0;
            opcode_reg       <= 4'd0;
            key_index_reg    <= 2'd0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            header_count_reg <= header_count_next;
            length_reg       <= length_next;
            remaining_reg    <= remaining_next;
            mask_key_reg     <= mask_key_next;
            masked_reg       <= masked_next;
            opcode_reg       <= opcode_next;
            key_index_reg    <= key_index_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (accept && emit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            kind_reg           <= res_kind;
            payload_byte_reg   <= res_byte;
            res_opcode_reg     <= opcode_next;
            payload_length_reg <= res_length;
            header_length_reg  <= res_hlen;
            last_reg           <= res_last;
        end
    end

    assign result_valid   = result_valid_reg;
    assign kind           = kind_reg;
    assign payload_byte   = payload_byte_reg;
    assign opcode         = res_opcode_reg;
    assign payload_length = payload_length_reg;
    assign header_length  = header_length_reg;
    assign last           = last_reg;

endmodule

/* hdl/wsd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_checker
// port-level checks on the result words of the websocket frame deframer
// ----------------------------------------------------------------------------
module wsd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_stall,
    input logic [1:0]  kind,
    input logic [7:0]  payload_byte,
    input logic [63:0] payload_length,
    input logic [3:0]  header_length,
    input logic        last
);

    // error word closes the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == wsd_pkg::KIND_ERROR |-> last)
        else $error("error word without last");

    // header word is last exactly for an empty frame
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == wsd_pkg::KIND_HEADER |-> last == (payload_length == 64'd0))
        else $error("header last flag does not match length");

    // header length field in range
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == wsd_pkg::KIND_HEADER |->
            header_length >= 4'd2 && header_length <= 4'd14)
        else $error("header length out of range");

    // non-header words carry no lengths
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind != wsd_pkg::KIND_HEADER |->
            payload_length == 64'd0 && header_length == 4'd0)
        else $error("length fields set outside a header word");

    // held word stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(payload_byte) && $stable(kind))
        else $error("stalled result word changed");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .kind           (kind),
    .payload_byte   (payload_byte),
    .payload_length (payload_length),
    .header_length  (header_length),
    .last           (last)
);

/* sim/websocket_frame_deframer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_tb
// streams websocket frames into the deframer one byte per word and checks
// every header, payload and error word against a cycle-free software
// predictor; covers all length forms, masking, back-pressure and fin-clear
// lockout, with random idling on both sides
// ----------------------------------------------------------------------------
module websocket_frame_deframer_tb;

    localparam int HOLDOFF_CYCLES = 150;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_LIMIT    = 2000;
    localparam int RANDOM_ITEMS   = 480;

    typedef enum logic [1:0] {
        FORM_SHORT,
        FORM_EXT16,
        FORM_EXT64
    } len_form_t;

    typedef struct {
        wsd_pkg::kind_t kind;
        logic [7:0]     payload_byte;
        logic [3:0]     opcode;
        logic [63:0]    payload_length;
        logic [3:0]     header_length;
        logic           last;
    } deframer_word_t;

    logic        clk;
    logic        rst_n;
    logic        frame_valid;
    logic        frame_stall;
    logic [7:0]  frame_byte;
    logic        result_valid;
    logic        result_stall;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [3:0]  opcode;
    logic [63:0] payload_length;
    logic [3:0]  header_length;
    logic        last;

    // predictor state
    wsd_pkg::phase_t ph         = wsd_pkg::PH_FIRST;
    logic [3:0]      hdr_cnt    = '0;
    logic [63:0]     len_reg    = '0;
    logic [63:0]     remaining  = '0;
    logic [31:0]     key        = '0;
    logic            masked     = 1'b0;
    logic [3:0]      cur_opcode = '0;
    logic [1:0]      key_idx    = '0;

    deframer_word_t expected_words[$];

    int   error_count   = 0;
    int   bytes_sent    = 0;
    int   words_checked = 0;
    int   frames_sent   = 0;
    int   quiet_cycles  = 0;
    int   holdoff_left  = 0;
    logic holdoff_req   = 1'b0;
    logic idle_enable   = 1'b1;

    websocket_frame_deframer i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .frame_valid    (frame_valid),
        .frame_stall    (frame_stall),
        .frame_byte     (frame_byte),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .kind           (kind),
        .payload_byte   (payload_byte),
        .opcode         (opcode),
        .payload_length (payload_length),
        .header_length  (header_length),
        .last           (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    task automatic push_word(input wsd_pkg::kind_t k, input logic [7:0] pb,
                             input logic [3:0] op, input logic [63:0] plen,
                             input logic [3:0] hlen, input logic lst);
        deframer_word_t w;
        w.kind           = k;
        w.payload_byte   = pb;
        w.opcode         = op;
        w.payload_length = plen;
        w.header_length  = hlen;
        w.last           = lst;
        expected_words.push_back(w);
    endtask

    task automatic header_done();
        remaining = len_reg;
        key_idx   = '0;
        push_word(wsd_pkg::KIND_HEADER, 8'h00, cur_opcode, len_reg, hdr_cnt,
                  remaining == 64'd0);
        ph = (remaining == 64'd0) ? wsd_pkg::PH_FIRST : wsd_pkg::PH_PAYLOAD;
    endtask

    task automatic length_known();
        if (masked)
        begin
            key_idx = '0;
            key     = '0;
            ph      = wsd_pkg::PH_KEY;
        end
        else
            header_done();
    endtask

    // advance the predictor by one accepted frame byte
    task automatic deframe_byte(input logic [7:0] b);
        logic [7:0] k;
        case (ph)
            wsd_pkg::PH_FIRST:
            begin
                cur_opcode = b[3:0];
                hdr_cnt    = 4'd1;
                len_reg    = '0;
                if ((b & wsd_pkg::FIN_BIT) == 8'h00)
                begin
                    ph = wsd_pkg::PH_ERROR;
                    push_word(wsd_pkg::KIND_ERROR, 8'h00, cur_opcode, 64'd0, 4'd0, 1'b1);
                end
                else
                    ph = wsd_pkg::PH_SECOND;
            end
            wsd_pkg::PH_SECOND:
            begin
                masked  = b[7];
                hdr_cnt = wsd_pkg::HDR_BASE;
                len_reg = '0;
                if (b[6:0] == wsd_pkg::LEN_CODE16)
                    ph = wsd_pkg::PH_EXT16;
                else if (b[6:0] == wsd_pkg::LEN_CODE64)
                    ph = wsd_pkg::PH_EXT64;
                else
                begin
                    len_reg = 64'(b[6:0]);
                    length_known();
                end
            end
            wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64:
            begin
                len_reg = {len_reg[55:0], b};
                hdr_cnt = hdr_cnt + 4'd1;
                if ((ph == wsd_pkg::PH_EXT16 && hdr_cnt == wsd_pkg::HDR_END16) ||
                    (ph == wsd_pkg::PH_EXT64 && hdr_cnt == wsd_pkg::HDR_END64))
                    length_known();
            end
            wsd_pkg::PH_KEY:
            begin
                key     = {key[23:0], b};
                hdr_cnt = hdr_cnt + 4'd1;
                if (key_idx == 2'd3)
                begin
                    key_idx = '0;
                    header_done();
                end
                else
                    key_idx = key_idx + 2'd1;
            end
            wsd_pkg::PH_PAYLOAD:
            begin
                k         = masked ? 8'(key >> (8 * (3 - int'(key_idx)))) : 8'h00;
                key_idx   = key_idx + 2'd1;
                remaining = remaining - 64'd1;
                if (remaining == 64'd0)
                    ph = wsd_pkg::PH_FIRST;
                push_word(wsd_pkg::KIND_PAYLOAD, b ^ k, cur_opcode, 64'd0, 4'd0,
                          remaining == 64'd0);
            end
            default:
            begin
            end
        endcase
    endtask

    // offer one word, hold it until taken, then predict
    task automatic send_byte(input logic [7:0] b);
        while (idle_enable && $urandom_range(99) < 6)
        begin
            frame_valid <= 1'b0;
            frame_byte  <= 8'($urandom_range(255));
            @(posedge clk);
        end
        frame_valid <= 1'b1;
        frame_byte  <= b;
        @(posedge clk);
        while (frame_stall)
            @(posedge clk);
        bytes_sent++;
        deframe_byte(b);
    endtask

    task automatic send_frame(input logic [3:0] op, input logic [2:0] rsv, input logic mask_on,
                              input len_form_t form, input logic [63:0] len,
                              input logic [31:0] mkey);
        send_byte({1'b1, rsv, op});
        case (form)
            FORM_SHORT:
                send_byte({mask_on, len[6:0]});
            FORM_EXT16:
            begin
                send_byte({mask_on, wsd_pkg::LEN_CODE16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            default:
            begin
                send_byte({mask_on, wsd_pkg::LEN_CODE64});
                for (int i = 7; i >= 0; i--)
                    send_byte(len[8 * i +: 8]);
            end
        endcase
        if (mask_on)
            for (int i = 3; i >= 0; i--)
                send_byte(mkey[8 * i +: 8]);
        for (longint unsigned i = 0; i < len; i++)
            send_byte(8'($urandom_range(255)));
        frames_sent++;
    endtask

    task automatic test_directed_frames();
        send_frame(4'hF, 3'b000, 1'b0, FORM_SHORT, 64'd0, 32'h0);
        send_frame(4'h1, 3'b111, 1'b1, FORM_SHORT, 64'd5, 32'hA5C3_0F81);
        send_frame(4'h2, 3'b010, 1'b0, FORM_EXT16, 64'd2, 32'h0);
        send_frame(4'h0, 3'b101, 1'b0, FORM_EXT64, 64'd1, 32'h0);
    endtask

    task automatic test_random_frames(input int target);
        int          start;
        int          pick;
        len_form_t   form;
        logic [63:0] len;
        start = bytes_sent;
        while (bytes_sent - start < target)
        begin
            // quiet stretch in the middle third: no idling on either side
            idle_enable <= !((bytes_sent - start) > target / 3 &&
                             (bytes_sent - start) < 2 * target / 3);
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                form = FORM_SHORT;
                len  = 64'($urandom_range(12));
            end
            else if (pick < 65)
            begin
                form = FORM_SHORT;
                len  = 64'($urandom_range(125));
            end
            else if (pick < 80)
            begin
                form = FORM_EXT16;
                len  = 64'($urandom_range(20));
            end
            else if (pick < 83)
            begin
                form = FORM_EXT16;
                len  = 64'($urandom_range(260, 126));
            end
            else
            begin
                form = FORM_EXT64;
                len  = 64'($urandom_range(20));
            end
            send_frame(4'($urandom_range(15)), 3'($urandom_range(7)), 1'($urandom_range(1)),
                       form, len, $urandom);
        end
        idle_enable <= 1'b1;
    endtask

    task automatic test_result_holdoff();
        holdoff_req <= 1'b1;
        send_frame(4'h9, 3'b000, 1'b1, FORM_SHORT, 64'd60, $urandom);
    endtask

    task automatic test_fin_clear_lockout();
        send_byte({1'b0, 3'($urandom_range(7)), 4'hA});
        // everything after this is dropped by the block
        repeat (20)
            send_byte(8'($urandom_range(255)));
    endtask

    // receiver: random stall, or a long hold-off when requested
    always @(posedge clk)
    begin
        if (holdoff_left != 0)
        begin
            result_stall <= 1'b1;
            holdoff_left <= holdoff_left - 1;
        end
        else if (holdoff_req)
        begin
            result_stall <= 1'b1;
            holdoff_left <= HOLDOFF_CYCLES;
            holdoff_req  <= 1'b0;
        end
        else
            result_stall <= idle_enable && ($urandom_range(99) < 6);
    end

    always @(posedge clk)
    begin : check_result
        deframer_word_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            words_checked++;
            if (expected_words.size() == 0)
            begin
                $error("unexpected result word: kind %0d opcode %0h", kind, opcode);
                error_count++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, kind);
                    error_count++;
                end
                if (payload_byte !== want.payload_byte)
                begin
                    $error("payload_byte: expected %02h, got %02h", want.payload_byte,
                           payload_byte);
                    error_count++;
                end
                if (opcode !== want.opcode)
                begin
                    $error("opcode: expected %0h, got %0h", want.opcode, opcode);
                    error_count++;
                end
                if (payload_length !== want.payload_length)
                begin
                    $error("payload_length: expected %0d, got %0d", want.payload_length,
                           payload_length);
                    error_count++;
                end
                if (header_length !== want.header_length)
                begin
                    $error("header_length: expected %0d, got %0d", want.header_length,
                           header_length);
                    error_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((frame_valid && !frame_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : run_tests
        int drain;
        rst_n        = 1'b0;
        frame_valid  = 1'b0;
        frame_byte   = 8'h00;
        result_stall = 1'b0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_frames();
        test_result_holdoff();
        test_random_frames(RANDOM_ITEMS);
        test_fin_clear_lockout();

        frame_valid <= 1'b0;
        drain = 0;
        while (expected_words.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (10)
            @(posedge clk);
        if (expected_words.size() != 0)
        begin
            $error("%0d expected result words never arrived", expected_words.size());
            error_count++;
        end

        $display("%0d frames, %0d bytes in, %0d result words checked", frames_sent, bytes_sent,
                 words_checked);
        $display("short/16-bit/64-bit lengths, masked and clear data, hold-off, fin-clear lockout");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
